// ----- sv/tcbm_pkg.sv -----
// ----------------------------------------------------------------------------
// tcbm_pkg
// shared codes, state encoding and control/status bundles of the classifier
// ----------------------------------------------------------------------------
`default_nettype none

package tcbm_pkg;

  localparam int ADDR_W  = 32;
  localparam int PLEN_W  = 6;
  localparam int PORT_W  = 16;
  localparam int PROTO_W = 8;
  localparam int BYTES_W = 16;
  localparam int CNT_W   = 32;
  localparam int SCORE_W = 10;
  localparam int CC_W    = 5;
  localparam int PMP_W   = 8;
  localparam int OP_W    = 3;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 80;
  localparam int APB_AW  = 3;

  localparam logic [OP_W-1:0] OP_LOAD_SUBNET = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_PORT   = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_SUBNETS = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_PORTS   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLASSIFY    = 3'd4;
  localparam logic [OP_W-1:0] OP_READ        = 3'd5;

  localparam logic REG_CLASS_COUNT = 1'b0;
  localparam logic REG_PORT_POINTS = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_DISPATCH  = 10'b0000000010,
    ST_WRITE     = 10'b0000000100,
    ST_CLS_START = 10'b0000001000,
    ST_LST_START = 10'b0000010000,
    ST_LST_CHECK = 10'b0000100000,
    ST_RD        = 10'b0001000000,
    ST_EVAL      = 10'b0010000000,
    ST_CLS_END   = 10'b0100000000,
    ST_FINISH    = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic cap;
    logic wr;
    logic cls_start;
    logic lst_start;
    logic rd;
    logic lst_score;
    logic nxt_entry;
    logic cls_end;
    logic fin;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic no_class;
    logic len_zero;
    logic hit;
    logic entry_last;
    logic list_last;
    logic class_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/tcbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcbm_ctrl
// sequencer that walks classes, lists and entries for one item at a time
// ----------------------------------------------------------------------------
`default_nettype none

module tcbm_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  tcbm_pkg::sts_t   sts,
  output tcbm_pkg::cmd_t   cmd
);

  tcbm_pkg::state_t state, state_next;
  logic result_pend, result_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tcbm_pkg::ST_IDLE;
      result_pend <= 1'b0;
    end else begin
      state       <= state_next;
      result_pend <= result_pend_next;
    end
  end

  assign in_ready = (state == tcbm_pkg::ST_IDLE) && !result_pend;

  always_comb begin
    cmd              = '0;
    state_next       = state;
    result_pend_next = result_pend;
    // a finished item waits here until the output register is free
    if (result_pend && !sts.out_busy) begin
      cmd.out_load     = 1'b1;
      result_pend_next = 1'b0;
    end
    unique case (state)
      tcbm_pkg::ST_IDLE: begin
        if (in_valid && !result_pend) begin
          cmd.cap    = 1'b1;
          state_next = tcbm_pkg::ST_DISPATCH;
        end
      end
      tcbm_pkg::ST_DISPATCH: begin
        case (sts.op) inside
          tcbm_pkg::OP_LOAD_SUBNET, tcbm_pkg::OP_LOAD_PORT,
          tcbm_pkg::OP_SET_SUBNETS, tcbm_pkg::OP_SET_PORTS: begin
            state_next = tcbm_pkg::ST_WRITE;
          end
          tcbm_pkg::OP_CLASSIFY: begin
            state_next = sts.no_class ? tcbm_pkg::ST_FINISH : tcbm_pkg::ST_CLS_START;
          end
          default: begin
            result_pend_next = 1'b1;
            state_next       = tcbm_pkg::ST_IDLE;
          end
        endcase
      end
      tcbm_pkg::ST_WRITE: begin
        cmd.wr           = 1'b1;
        result_pend_next = 1'b1;
        state_next       = tcbm_pkg::ST_IDLE;
      end
      tcbm_pkg::ST_CLS_START: begin
        cmd.cls_start = 1'b1;
        state_next    = tcbm_pkg::ST_LST_START;
      end
      tcbm_pkg::ST_LST_START: begin
        cmd.lst_start = 1'b1;
        state_next    = tcbm_pkg::ST_LST_CHECK;
      end
      tcbm_pkg::ST_LST_CHECK: begin
        if (sts.len_zero) begin
          cmd.lst_score = 1'b1;
          state_next = sts.list_last ? tcbm_pkg::ST_CLS_END : tcbm_pkg::ST_LST_START;
        end else begin
          state_next = tcbm_pkg::ST_RD;
        end
      end
      tcbm_pkg::ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = tcbm_pkg::ST_EVAL;
      end
      tcbm_pkg::ST_EVAL: begin
        if (sts.hit || sts.entry_last) begin
          cmd.lst_score = 1'b1;
          state_next = sts.list_last ? tcbm_pkg::ST_CLS_END : tcbm_pkg::ST_LST_START;
        end else begin
          cmd.nxt_entry = 1'b1;
          state_next    = tcbm_pkg::ST_RD;
        end
      end
      tcbm_pkg::ST_CLS_END: begin
        cmd.cls_end = 1'b1;
        state_next  = sts.class_last ? tcbm_pkg::ST_FINISH : tcbm_pkg::ST_CLS_START;
      end
      tcbm_pkg::ST_FINISH: begin
        cmd.fin          = 1'b1;
        result_pend_next = 1'b1;
        state_next       = tcbm_pkg::ST_IDLE;
      end
      default: begin
        state_next = tcbm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/tcbm_dp.sv -----
// ----------------------------------------------------------------------------
// tcbm_dp
// list tables, entry matcher, score accumulator, counters and output register
// ----------------------------------------------------------------------------
`default_nettype none

module tcbm_dp #(
  parameter int NUM_CLASSES = 16,
  parameter int LIST_DEPTH  = 4
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  tcbm_pkg::cmd_t                        cmd,
  output tcbm_pkg::sts_t                        sts,
  input  wire [tcbm_pkg::IN_TDATA_W-1:0]        in_data,
  input  wire [tcbm_pkg::OP_W-1:0]              in_op,
  input  wire [tcbm_pkg::CC_W-1:0]              class_count,
  input  wire [tcbm_pkg::PMP_W-1:0]             port_match_points,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [tcbm_pkg::OUT_TDATA_W-1:0]      out_data
);

  localparam int CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int ENT_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LEN_W = $clog2(LIST_DEPTH + 1);
  localparam int LST_W = CLS_W + 1;
  localparam int MA_W  = LST_W + ENT_W;
  localparam int MEM_DEPTH = 2 ** MA_W;
  localparam int SUB_W = tcbm_pkg::PLEN_W + tcbm_pkg::ADDR_W;
  localparam int PRT_W = tcbm_pkg::PROTO_W + tcbm_pkg::PORT_W;

  // captured item
  logic [tcbm_pkg::OP_W-1:0]    op;
  logic [3:0]                   cls_in;
  logic                         side_in;
  logic [2:0]                   slot_in;
  logic [tcbm_pkg::ADDR_W-1:0]  src, dst;
  logic [tcbm_pkg::PLEN_W-1:0]  plen;
  logic [tcbm_pkg::PORT_W-1:0]  sport, dport;
  logic [tcbm_pkg::PROTO_W-1:0] proto;
  logic                         inb;
  logic [tcbm_pkg::BYTES_W-1:0] bytes;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op      <= in_op;
      cls_in  <= in_data[3:0];
      side_in <= in_data[4];
      slot_in <= in_data[7:5];
      src     <= in_data[39:8];
      dst     <= in_data[71:40];
      plen    <= in_data[77:72];
      sport   <= in_data[93:78];
      dport   <= in_data[109:94];
      proto   <= in_data[117:110];
      inb     <= in_data[118];
      bytes   <= in_data[134:119];
    end
  end

  logic             cls_ok, slot_ok;
  logic [CLS_W-1:0] cls_ext;
  logic [LST_W-1:0] wr_list;
  logic [MA_W-1:0]  wr_addr;
  logic [LEN_W-1:0] wr_len;

  assign cls_ok  = 32'(cls_in) < NUM_CLASSES;
  assign slot_ok = 32'(slot_in) < LIST_DEPTH;
  assign cls_ext = CLS_W'(cls_in);
  assign wr_list = {cls_ext, side_in};
  assign wr_addr = {wr_list, ENT_W'(slot_in)};
  assign wr_len  = (32'(slot_in) > LIST_DEPTH) ? LEN_W'(LIST_DEPTH) : LEN_W'(slot_in);

  // entry tables
  logic [SUB_W-1:0] sub_mem [MEM_DEPTH];
  logic [PRT_W-1:0] prt_mem [MEM_DEPTH];
  logic [SUB_W-1:0] sub_q;
  logic [PRT_W-1:0] prt_q;

  // walk position
  logic [CLS_W-1:0] class_cur;
  logic [1:0]       list_cur;
  logic [ENT_W-1:0] entry_cur;
  logic [LEN_W-1:0] len_cur;
  logic [LST_W-1:0] rd_list;
  logic [MA_W-1:0]  rd_addr;

  assign rd_list = {class_cur, list_cur[0]};
  assign rd_addr = {rd_list, entry_cur};

  always_ff @(posedge clk) begin
    if (cmd.wr && cls_ok && slot_ok && op == tcbm_pkg::OP_LOAD_SUBNET) begin
      sub_mem[wr_addr] <= {((plen > 6'd32) ? 6'd32 : plen), src};
    end
    if (cmd.rd) begin
      sub_q <= sub_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && cls_ok && slot_ok && op == tcbm_pkg::OP_LOAD_PORT) begin
      prt_mem[wr_addr] <= {proto, sport};
    end
    if (cmd.rd) begin
      prt_q <= prt_mem[rd_addr];
    end
  end

  // list lengths
  logic [LEN_W-1:0] sub_len [2*NUM_CLASSES];
  logic [LEN_W-1:0] prt_len [2*NUM_CLASSES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2*NUM_CLASSES; i++) begin
        sub_len[i] <= '0;
        prt_len[i] <= '0;
      end
    end else if (cmd.wr && cls_ok) begin
      if (op == tcbm_pkg::OP_SET_SUBNETS) sub_len[wr_list] <= wr_len;
      if (op == tcbm_pkg::OP_SET_PORTS)   prt_len[wr_list] <= wr_len;
    end
  end

  // entry match
  logic [tcbm_pkg::ADDR_W-1:0]  out_addr, in_addr, addr_sel, mask;
  logic [tcbm_pkg::PORT_W-1:0]  out_port, in_port, port_sel;
  logic [tcbm_pkg::PLEN_W-1:0]  q_len;
  logic [tcbm_pkg::ADDR_W-1:0]  q_net;
  logic [tcbm_pkg::PORT_W-1:0]  q_port;
  logic [tcbm_pkg::PROTO_W-1:0] q_proto;
  logic                         hit;
  logic [tcbm_pkg::SCORE_W-1:0] hit_score, list_score;

  assign out_addr = inb ? src : dst;
  assign in_addr  = inb ? dst : src;
  assign out_port = inb ? sport : dport;
  assign in_port  = inb ? dport : sport;
  assign addr_sel = list_cur[0] ? in_addr : out_addr;
  assign port_sel = list_cur[0] ? in_port : out_port;
  assign {q_len, q_net}    = sub_q;
  assign {q_proto, q_port} = prt_q;
  assign mask = ~(32'hFFFF_FFFF >> q_len);

  always_comb begin
    if (list_cur[1]) begin
      hit = (q_port == port_sel) && (q_proto == '0 || q_proto == proto);
      hit_score = tcbm_pkg::SCORE_W'(port_match_points) + 1'b1;
    end else begin
      hit = (q_len != '0) && (((addr_sel ^ q_net) & mask) == '0);
      hit_score = tcbm_pkg::SCORE_W'(q_len);
    end
    if (len_cur == '0) list_score = tcbm_pkg::SCORE_W'(1);
    else if (hit)      list_score = hit_score;
    else               list_score = '0;
  end

  // class accumulation and best tracking
  logic [tcbm_pkg::SCORE_W-1:0] sum, best;
  logic                         fail;
  logic [CLS_W-1:0]             winner;
  logic [31:0]                  limit;

  assign limit = (32'(class_count) > NUM_CLASSES) ? NUM_CLASSES : 32'(class_count);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      class_cur <= CLS_W'(1);
      best      <= '0;
      winner    <= '0;
    end
    if (cmd.cls_start) begin
      sum      <= '0;
      fail     <= 1'b0;
      list_cur <= '0;
    end
    if (cmd.lst_start) begin
      len_cur   <= list_cur[1] ? prt_len[rd_list] : sub_len[rd_list];
      entry_cur <= '0;
    end
    if (cmd.nxt_entry) entry_cur <= entry_cur + 1'b1;
    if (cmd.lst_score) begin
      sum      <= sum + list_score;
      fail     <= fail | (list_score == '0);
      list_cur <= list_cur + 1'b1;
    end
    if (cmd.cls_end) begin
      if (!fail && sum > best) begin
        best   <= sum;
        winner <= class_cur;
      end
      class_cur <= class_cur + 1'b1;
    end
  end

  // byte counters
  logic [tcbm_pkg::CNT_W-1:0] up_cnt [NUM_CLASSES];
  logic [tcbm_pkg::CNT_W-1:0] dn_cnt [NUM_CLASSES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        up_cnt[i] <= '0;
        dn_cnt[i] <= '0;
      end
    end else if (cmd.fin) begin
      if (inb) dn_cnt[winner] <= dn_cnt[winner] + tcbm_pkg::CNT_W'(bytes);
      else     up_cnt[winner] <= up_cnt[winner] + tcbm_pkg::CNT_W'(bytes);
    end
  end

  // output register
  logic                         r_matched;
  logic [3:0]                   r_class;
  logic [tcbm_pkg::SCORE_W-1:0] r_score;
  logic [tcbm_pkg::CNT_W-1:0]   r_up, r_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      r_matched <= 1'b0;
      r_class   <= '0;
      r_score   <= '0;
      r_up      <= '0;
      r_dn      <= '0;
      if (op == tcbm_pkg::OP_CLASSIFY) begin
        r_matched <= best != '0;
        r_class   <= 4'(winner);
        r_score   <= best;
      end else if (op == tcbm_pkg::OP_READ && cls_ok) begin
        r_up <= up_cnt[cls_ext];
        r_dn <= dn_cnt[cls_ext];
      end
    end
  end

  assign out_data = {1'b0, r_dn, r_up, r_score, r_class, r_matched};

  assign sts.op         = op;
  assign sts.no_class   = limit <= 32'd1;
  assign sts.len_zero   = len_cur == '0;
  assign sts.hit        = hit;
  assign sts.entry_last = (32'(entry_cur) + 32'd1) >= 32'(len_cur);
  assign sts.list_last  = list_cur == 2'd3;
  assign sts.class_last = (32'(class_cur) + 32'd1) >= limit;
  assign sts.out_busy   = out_valid && !out_ready;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a pending transfer");
  a_rd_in_list: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |-> (32'(entry_cur) < 32'(len_cur)))
    else $error("entry read past list length");
  a_win_score: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && op == tcbm_pkg::OP_CLASSIFY) |-> ((best == '0) == (winner == '0)))
    else $error("winner and best score disagree");
`endif

endmodule

`default_nettype wire

// ----- sv/traffic_class_best_match.sv -----
// ----------------------------------------------------------------------------
// traffic_class_best_match
// multi-field packet classifier: scores packets against per-class lists
// ----------------------------------------------------------------------------
// loads and list lengths pass the dispatch and write states; counter reads
// go from dispatch to the output register; classify walks classes from 1,
// each with a class start, per list a start and a check, for a non-empty list
// entry read and evaluate steps until a hit or the last entry, then class end;
// one item at a time; a result may wait in the output register meanwhile;
// synchronous reset clears list lengths, byte counters, state and output valid
`default_nettype none

module traffic_class_best_match #(
  parameter int NUM_CLASSES = 16,
  parameter int LIST_DEPTH  = 4
) (
  input  wire                               clk,
  input  wire                               rst,
  // class_index, list_side, entry_slot, source_address, dest_address,
  // prefix_length, source_port, dest_port, protocol, inbound, byte_count
  input  wire [tcbm_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  wire [tcbm_pkg::OP_W-1:0]          s_tuser,   // operation
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // matched, class_out, best_score, upload_bytes, download_bytes
  output logic [tcbm_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [tcbm_pkg::APB_AW-1:0]        paddr,
  input  wire [31:0]                        pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // configuration registers
  logic [tcbm_pkg::CC_W-1:0]  class_count;
  logic [tcbm_pkg::PMP_W-1:0] port_match_points;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count       <= tcbm_pkg::CC_W'(1);
      port_match_points <= tcbm_pkg::PMP_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        tcbm_pkg::REG_CLASS_COUNT: class_count       <= pwdata[tcbm_pkg::CC_W-1:0];
        tcbm_pkg::REG_PORT_POINTS: port_match_points <= pwdata[tcbm_pkg::PMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tcbm_pkg::REG_CLASS_COUNT: prdata = 32'(class_count);
      tcbm_pkg::REG_PORT_POINTS: prdata = 32'(port_match_points);
      default:                   prdata = '0;
    endcase
  end

  // sequencer and datapath talk only through command and status bundles
  tcbm_pkg::cmd_t cmd;
  tcbm_pkg::sts_t sts;

  tcbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcbm_dp #(
    .NUM_CLASSES (NUM_CLASSES),
    .LIST_DEPTH  (LIST_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_data           (s_tdata),
    .in_op             (s_tuser),
    .class_count       (class_count),
    .port_match_points (port_match_points),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_data          (m_tdata)
  );

endmodule

`default_nettype wire

// ----- dv/traffic_class_best_match_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_class_best_match_test
// self-checking bench for the best-match traffic classifier: drives table
// loads, list lengths, classify and counter reads over the stream port,
// predicts every result, compares the whole word and reports mismatches by field
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_class_best_match_test;

  localparam int NCLS  = 16;
  localparam int DEPTH = 4;
  localparam int NLIST = NCLS * 2;
  localparam int DRAIN_CYCLES = 800;

  localparam logic [tcbm_pkg::OP_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [tcbm_pkg::OP_W-1:0] OP_UNUSED_B = 3'd7;
  localparam logic [tcbm_pkg::APB_AW-1:0] ADDR_CLASS_COUNT = 3'd0;
  localparam logic [tcbm_pkg::APB_AW-1:0] ADDR_PORT_POINTS = 3'd4;

  typedef struct {
    logic [tcbm_pkg::OP_W-1:0] op;
    logic [3:0]      cls;
    logic            side;
    logic [2:0]      slot;
    logic [31:0]     src;
    logic [31:0]     dst;
    logic [5:0]      plen;
    logic [15:0]     sport;
    logic [15:0]     dport;
    logic [7:0]      proto;
    logic            inb;
    logic [15:0]     nbytes;
  } pkt_item_t;

  typedef struct {
    logic        matched;
    logic [3:0]  class_out;
    logic [9:0]  score;
    logic [31:0] up;
    logic [31:0] down;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [tcbm_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic [tcbm_pkg::OP_W-1:0]        s_tuser = '0;
  logic                             s_tvalid = 1'b0;
  wire                              s_tready;
  wire [tcbm_pkg::OUT_TDATA_W-1:0]  m_tdata;
  wire                              m_tvalid;
  logic                             m_tready = 1'b0;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [tcbm_pkg::APB_AW-1:0]      paddr = '0;
  logic [31:0]                      pwdata = '0;
  wire [31:0]                       prdata;
  wire                              pready;

  traffic_class_best_match dut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // shadow copy of the classifier state
  logic [4:0]  cls_count_q = 5'd1;
  logic [7:0]  port_points_q = 8'd1;
  logic [31:0] sub_net [DEPTH*NLIST];
  logic [5:0]  sub_plen [DEPTH*NLIST];
  logic [15:0] prt_num [DEPTH*NLIST];
  logic [7:0]  prt_proto [DEPTH*NLIST];
  bit          sub_written [DEPTH*NLIST];
  bit          prt_written [DEPTH*NLIST];
  int unsigned sub_len_q [NLIST];
  int unsigned prt_len_q [NLIST];
  logic [31:0] up_cnt [NCLS];
  logic [31:0] down_cnt [NCLS];

  verdict_t    pending_q[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          classifies = 0;
  int          class_hits = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_left = 0;
  logic [31:0] addr_pool [4];
  logic [15:0] port_pool [4];

  initial begin
    for (int i = 0; i < NLIST; i++) begin
      sub_len_q[i] = 0;
      prt_len_q[i] = 0;
    end
    for (int i = 0; i < NCLS; i++) begin
      up_cnt[i] = '0;
      down_cnt[i] = '0;
    end
  end

  function automatic int unsigned subnet_score(int l, logic [31:0] a);
    int k;
    logic [31:0] m;
    if (sub_len_q[l] == 0) return 1;
    for (int i = 0; i < sub_len_q[l]; i++) begin
      k = l * DEPTH + i;
      m = (sub_plen[k] == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - sub_plen[k]));
      if (((a ^ sub_net[k]) & m) == 0 && sub_plen[k] != 0) return 32'(sub_plen[k]);
    end
    return 0;
  endfunction

  function automatic int unsigned port_score(int l, logic [15:0] p, logic [7:0] pr);
    int k;
    if (prt_len_q[l] == 0) return 1;
    for (int i = 0; i < prt_len_q[l]; i++) begin
      k = l * DEPTH + i;
      if (prt_num[k] == p && (prt_proto[k] == 0 || prt_proto[k] == pr))
        return 1 + port_points_q;
    end
    return 0;
  endfunction

  // applies one item to the shadow state and gives the result it causes
  function automatic verdict_t classify_predict(pkt_item_t it);
    verdict_t v;
    int l, k, lim;
    int unsigned a, b, p, q, s, best, win;
    logic [31:0] oa, ia;
    logic [15:0] op_, ip_;
    v = '{default: '0};
    l = it.cls * 2 + it.side;
    k = l * DEPTH + it.slot;
    case (it.op)
      tcbm_pkg::OP_LOAD_SUBNET: if (it.slot < DEPTH) begin
        sub_net[k] = it.src;
        sub_plen[k] = (it.plen > 32) ? 6'd32 : it.plen;
        sub_written[k] = 1'b1;
      end
      tcbm_pkg::OP_LOAD_PORT: if (it.slot < DEPTH) begin
        prt_num[k] = it.sport;
        prt_proto[k] = it.proto;
        prt_written[k] = 1'b1;
      end
      tcbm_pkg::OP_SET_SUBNETS: sub_len_q[l] = (it.slot > DEPTH) ? DEPTH : it.slot;
      tcbm_pkg::OP_SET_PORTS:   prt_len_q[l] = (it.slot > DEPTH) ? DEPTH : it.slot;
      tcbm_pkg::OP_CLASSIFY: begin
        oa  = it.inb ? it.src : it.dst;
        ia  = it.inb ? it.dst : it.src;
        op_ = it.inb ? it.sport : it.dport;
        ip_ = it.inb ? it.dport : it.sport;
        lim = (cls_count_q > NCLS) ? NCLS : cls_count_q;
        best = 0;
        win = 0;
        for (int c = 1; c < lim; c++) begin
          a = subnet_score(c * 2, oa);
          b = subnet_score(c * 2 + 1, ia);
          p = port_score(c * 2, op_, it.proto);
          q = port_score(c * 2 + 1, ip_, it.proto);
          s = (a != 0 && b != 0 && p != 0 && q != 0) ? a + b + p + q : 0;
          if (s > best) begin
            best = s;
            win = c;
          end
        end
        if (it.inb) down_cnt[win] = down_cnt[win] + it.nbytes;
        else up_cnt[win] = up_cnt[win] + it.nbytes;
        v.matched = (best > 0);
        v.class_out = win[3:0];
        v.score = best[9:0];
        classifies++;
        if (best > 0) class_hits++;
      end
      tcbm_pkg::OP_READ: begin
        v.up = up_cnt[it.cls];
        v.down = down_cnt[it.cls];
      end
      default: ;
    endcase
    return v;
  endfunction

  // offer one transfer and keep it up until accepted
  task automatic send_item(pkt_item_t it);
    s_tdata <= {1'b0, it.nbytes, it.inb, it.proto, it.dport, it.sport, it.plen,
                it.dst, it.src, it.slot, it.side, it.cls};
    s_tuser <= it.op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_q.push_back(classify_predict(it));
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // let every expected result come back, then give the block time to settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [tcbm_pkg::APB_AW-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_CLASS_COUNT) cls_count_q = data[4:0];
    else port_points_q = data[7:0];
  endtask

  // read a register back and compare with the shadow value
  task automatic apb_check(logic [tcbm_pkg::APB_AW-1:0] addr, logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register read mismatch at %0d: %h/%h (expected/actual)",
                 addr, want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [4:0] cc, logic [7:0] pts);
    wait_idle();
    apb_write(ADDR_CLASS_COUNT, {27'd0, cc});
    apb_write(ADDR_PORT_POINTS, {24'd0, pts});
    apb_check(ADDR_CLASS_COUNT, {27'd0, cls_count_q});
    apb_check(ADDR_PORT_POINTS, {24'd0, port_points_q});
  endtask

  function automatic pkt_item_t blank_item(logic [tcbm_pkg::OP_W-1:0] op, int cls,
                                           int side, int slot);
    pkt_item_t it;
    it.op = op; it.cls = 4'(cls); it.side = 1'(side); it.slot = 3'(slot);
    it.src = $urandom; it.dst = $urandom; it.plen = 6'($urandom_range(0, 63));
    it.sport = 16'($urandom); it.dport = 16'($urandom); it.proto = 8'($urandom);
    it.inb = 1'($urandom); it.nbytes = 16'($urandom);
    return it;
  endfunction

  function automatic logic [31:0] pool_addr();
    return addr_pool[$urandom_range(3)] ^ ($urandom >> $urandom_range(0, 31));
  endfunction

  task automatic load_subnet(int cls, int side, int slot, logic [31:0] net, int pl);
    pkt_item_t it;
    it = blank_item(tcbm_pkg::OP_LOAD_SUBNET, cls, side, slot);
    it.src = net;
    it.plen = 6'(pl);
    send_item(it);
  endtask

  task automatic load_port(int cls, int side, int slot, logic [15:0] pn, logic [7:0] pr);
    pkt_item_t it;
    it = blank_item(tcbm_pkg::OP_LOAD_PORT, cls, side, slot);
    it.sport = pn;
    it.proto = pr;
    send_item(it);
  endtask

  // a list length only goes out once the entries it covers are loaded
  task automatic set_length(logic [tcbm_pkg::OP_W-1:0] op, int cls, int side, int n);
    int need, k;
    need = (n > DEPTH) ? DEPTH : n;
    for (int i = 0; i < need; i++) begin
      k = (cls * 2 + side) * DEPTH + i;
      if (op == tcbm_pkg::OP_SET_SUBNETS && !sub_written[k])
        load_subnet(cls, side, i, pool_addr(), $urandom_range(0, 40));
      if (op == tcbm_pkg::OP_SET_PORTS && !prt_written[k])
        load_port(cls, side, i, port_pool[$urandom_range(3)],
                  $urandom_range(0, 1) ? 8'd0 : 8'd6);
    end
    send_item(blank_item(op, cls, side, n));
  endtask

  task automatic classify(logic [31:0] src, logic [31:0] dst, logic [15:0] sp,
                          logic [15:0] dp, logic [7:0] pr, logic inb, logic [15:0] nb);
    pkt_item_t it;
    it = blank_item(tcbm_pkg::OP_CLASSIFY, $urandom_range(0, 15), $urandom_range(0, 1),
                    $urandom_range(0, 7));
    it.src = src; it.dst = dst; it.sport = sp; it.dport = dp;
    it.proto = pr; it.inb = inb; it.nbytes = nb;
    send_item(it);
  endtask

  // ---------------------------------------------------------------- tests

  // field extremes, every operation and each corner of the scoring rules
  task automatic test_directed();
    send_item(blank_item(tcbm_pkg::OP_READ, 15, 0, 0));    // counters start at zero
    classify(32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0, 8'hFF, 1'b1, 16'hFFFF);  // one class only
    send_item(blank_item(OP_UNUSED_A, 1, 1, 7));
    send_item(blank_item(OP_UNUSED_B, 15, 0, 0));
    set_config(5'd31, 8'd255);                              // count above class total
    load_subnet(1, 0, 0, 32'h0A01_0203, 0);                 // address matches but prefix is zero
    load_subnet(1, 0, 1, 32'hC0A8_0000, 40);                // prefix above 32 kept as 32
    load_subnet(1, 0, 2, 32'h0A00_0000, 8);
    load_subnet(1, 0, 3, 32'h0A01_0203, 32);
    load_subnet(1, 0, 5, 32'h0A00_0000, 1);                 // slot past list end is dropped
    send_item(blank_item(tcbm_pkg::OP_SET_SUBNETS, 1, 0, 7));  // length clamps to depth
    load_port(1, 0, 0, 16'd80, 8'd0);                       // wildcard protocol
    load_port(1, 1, 0, 16'hFFFF, 8'd17);
    set_length(tcbm_pkg::OP_SET_PORTS, 1, 0, 1);
    set_length(tcbm_pkg::OP_SET_PORTS, 1, 1, 1);
    load_port(2, 1, 6, 16'd1, 8'd1);
    classify(32'h0A01_0203, 32'h1, 16'd80, 16'hFFFF, 8'd17, 1'b1, 16'd1000);
    classify(32'h1, 32'h0A01_0203, 16'hFFFF, 16'd80, 8'd6, 1'b0, 16'd0);
    classify(32'h0A01_0203, 32'h1, 16'd80, 16'hFFFF, 8'd6, 1'b1, 16'd7);   // protocol miss
    classify(32'h0B00_0000, 32'h1, 16'd80, 16'hFFFF, 8'd17, 1'b1, 16'd5);  // subnet miss
    send_item(blank_item(tcbm_pkg::OP_READ, 1, 0, 0));
    send_item(blank_item(tcbm_pkg::OP_READ, 0, 1, 0));
  endtask

  // mostly well-formed table edits and packets aimed at the loaded lists
  task automatic test_random_traffic(int n_items);
    int target, pick, c, sd;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      c = $urandom_range(0, 15);
      if ($urandom_range(3) != 0) c = $urandom_range(1, 5);
      sd = $urandom_range(0, 1);
      if (pick < 40)
        classify(pool_addr(), pool_addr(), port_pool[$urandom_range(3)],
                 port_pool[$urandom_range(3)], $urandom_range(1) ? 8'd6 : 8'(($urandom)),
                 1'($urandom), 16'($urandom));
      else if (pick < 50)
        send_item(blank_item(tcbm_pkg::OP_READ, c, sd, $urandom_range(0, 7)));
      else if (pick < 63)
        load_subnet(c, sd, $urandom_range(0, 3), pool_addr(), $urandom_range(0, 63));
      else if (pick < 74)
        load_port(c, sd, $urandom_range(0, 3), port_pool[$urandom_range(3)],
                  $urandom_range(1) ? 8'd0 : 8'(($urandom)));
      else if (pick < 90)
        set_length($urandom_range(1) ? tcbm_pkg::OP_SET_SUBNETS : tcbm_pkg::OP_SET_PORTS,
                   c, sd, $urandom_range(0, 7));
      else if (pick < 95)
        send_item(blank_item($urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B, c, sd, 0));
      else
        send_item(blank_item($urandom_range(1) ? tcbm_pkg::OP_LOAD_SUBNET
                                               : tcbm_pkg::OP_LOAD_PORT,
                             c, sd, $urandom_range(4, 7)));
    end
  endtask

  // receiver holds off long enough that the block backs up onto its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left <= 3000;
    for (int i = 0; i < 12; i++)
      classify(pool_addr(), pool_addr(), port_pool[$urandom_range(3)],
               port_pool[$urandom_range(3)], 8'd6, 1'($urandom), 16'($urandom));
    wait_idle();
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    verdict_t e;
    logic [tcbm_pkg::OUT_TDATA_W-1:0] exp_word;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", m_tdata);
      end else begin
        e = pending_q.pop_front();
        exp_word = {1'b0, e.down, e.up, e.score, e.class_out, e.matched};
        if (m_tdata !== exp_word) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch (expected/actual): matched %0b/%0b class %0d/%0d",
                     e.matched, m_tdata[0], e.class_out, m_tdata[4:1]);
            $display("  score %0d/%0d up %h/%h down %h/%h",
                     e.score, m_tdata[14:5], e.up, m_tdata[46:15], e.down, m_tdata[78:47]);
          end
        end
      end
    end
  end

  // receiver ready, random stalls plus the long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    for (int i = 0; i < 4; i++) begin
      addr_pool[i] = $urandom;
      port_pool[i] = 16'($urandom);
    end
    port_pool[0] = 16'd80;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_config(5'd16, 8'd1);
    test_random_traffic(150);
    send_idle_pct = 83;
    set_config(5'd0, 8'd0);
    test_random_traffic(60);
    set_config(5'd31, 8'd255);
    test_random_traffic(90);
    send_idle_pct = 0;
    recv_stall_pct = 83;
    set_config(5'($urandom_range(2, 16)), 8'($urandom));
    test_random_traffic(150);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    set_config(5'($urandom_range(0, 31)), 8'($urandom));
    test_random_traffic(150);
    test_backpressure();
    wait_idle();
    $display("covered %0d transfers in, %0d classify packets of which %0d hit a class",
             items_sent, classifies, class_hits);
    if (mismatches == 0 && pending_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results outstanding", pending_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
